@@ sv/csa_pkg.sv @@
// ----------------------------------------------------------------------------
// CSR matrix assembly package
// Shared types, codes and default sizes for the CSR assembly block.
// ----------------------------------------------------------------------------
package csa_pkg;

  localparam int unsigned MAX_ROWS_DEF    = 1024;
  localparam int unsigned MAX_ENTRIES_DEF = 8192;
  localparam int unsigned POS_W           = 13;
  localparam int unsigned IDX_W           = 10;
  localparam int unsigned Q_W             = 32;

  localparam logic signed [63:0] ROUND_HALF = 64'sd32768;
  localparam logic [Q_W-1:0]     Q_MAX      = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0]     Q_MIN      = 32'h8000_0000;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ROW   = 2'd1,
    OP_ADJ   = 2'd2,
    OP_ADD   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]              op;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [Q_W-1:0]   value;
    logic signed [Q_W-1:0]   factor;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [POS_W-1:0] position;
  } out_item_t;

  typedef struct packed {
    op_e                     op;
    logic                    skip;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [Q_W-1:0]   value;
    logic signed [Q_W-1:0]   factor;
  } cmd_t;

endpackage

@@ sv/csa_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module csa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ sv/csa_front.sv @@
// ----------------------------------------------------------------------------
// CSR assembly front end
// Accepts transactions, decodes them into commands and queues them.
// ----------------------------------------------------------------------------
module csa_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  csa_pkg::in_item_t req_i,
  output logic            head_valid_o,
  output csa_pkg::cmd_t   head_o,
  input  logic            pop_i
);
  import csa_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;
  cmd_t       cmd;

  always_comb begin
    cmd        = '0;
    cmd.op     = op_e'(req_i.op);
    cmd.skip   = (req_i.factor == '0);
    cmd.row    = req_i.row;
    cmd.col    = req_i.col;
    cmd.value  = req_i.value;
    cmd.factor = req_i.factor;
  end

  assign busy         = (cnt_q == 2'd2);
  assign push         = start && !busy;
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

endmodule

@@ sv/csa_back.sv @@
// ----------------------------------------------------------------------------
// CSR assembly back end
// Executes queued commands against the row pointer, column and value stores.
// ----------------------------------------------------------------------------
module csa_back #(
  parameter int unsigned MAX_ROWS    = csa_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_ENTRIES = csa_pkg::MAX_ENTRIES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  csa_pkg::cmd_t      head_i,
  output logic               pop_o,
  output logic               done_o,
  output csa_pkg::out_item_t res_o
);
  import csa_pkg::*;

  localparam int unsigned RW = $clog2(MAX_ROWS + 1);
  localparam int unsigned EW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ADJ_RD   = 4'd1;
  localparam logic [3:0] S_ADJ_CMP  = 4'd2;
  localparam logic [3:0] S_ADD_RS0  = 4'd3;
  localparam logic [3:0] S_ADD_RS1  = 4'd4;
  localparam logic [3:0] S_ADD_SCAN = 4'd5;
  localparam logic [3:0] S_ADD_CMP  = 4'd6;
  localparam logic [3:0] S_ADD_MUL  = 4'd7;
  localparam logic [3:0] S_ADD_ACC  = 4'd8;

  logic [3:0]   state_q, state_d;
  cmd_t         cmd_q, cmd_d;
  logic [EW-1:0] fill_q, fill_d, first_q, first_d, k_q, k_d, end_q, end_d, k_m1;
  logic [RW-1:0] row_cnt_q, row_cnt_d;
  logic signed [63:0] prod_q, prod_d, rq;
  logic signed [47:0] r48;
  logic signed [48:0] sum;
  logic [Q_W-1:0] sat;
  logic         done_d;
  out_item_t    res_d;

  logic          col_we;
  logic [AW-1:0] col_waddr, col_raddr;
  logic [IDX_W-1:0] col_wdata, col_rdata;
  logic          ev_we;
  logic [AW-1:0] ev_waddr;
  logic [Q_W-1:0] ev_wdata, ev_rdata;
  logic          rs_we;
  logic [RW-1:0] rs_waddr, rs_raddr;
  logic [EW-1:0] rs_wdata, rs_rdata;

  csa_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTRIES), .AW(AW)) u_col_ram (
    .clk_i, .we_i(col_we), .waddr_i(col_waddr), .wdata_i(col_wdata),
    .raddr_i(col_raddr), .rdata_o(col_rdata)
  );

  csa_ram #(.WIDTH(Q_W), .DEPTH(MAX_ENTRIES), .AW(AW)) u_val_ram (
    .clk_i, .we_i(ev_we), .waddr_i(ev_waddr), .wdata_i(ev_wdata),
    .raddr_i(k_q[AW-1:0]), .rdata_o(ev_rdata)
  );

  csa_ram #(.WIDTH(EW), .DEPTH(MAX_ROWS + 1), .AW(RW)) u_rs_ram (
    .clk_i, .we_i(rs_we), .waddr_i(rs_waddr), .wdata_i(rs_wdata),
    .raddr_i(rs_raddr), .rdata_o(rs_rdata)
  );

  assign k_m1 = k_q - 1'b1;
  assign rq   = prod_q + ROUND_HALF;
  assign r48  = rq[63:16];
  assign sum  = {{17{ev_rdata[Q_W-1]}}, ev_rdata} + {r48[47], r48};
  assign sat  = (&sum[48:31] || ~|sum[48:31]) ? sum[31:0] : (sum[48] ? Q_MIN : Q_MAX);

  always_comb begin
    col_raddr = k_q[AW-1:0];
    if (state_q == S_ADJ_RD) begin
      col_raddr = k_m1[AW-1:0];
    end
    rs_raddr = RW'(32'(cmd_q.row) + 32'd1);
    if (state_q == S_IDLE) begin
      rs_raddr = RW'(head_i.row);
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    fill_d    = fill_q;
    first_d   = first_q;
    row_cnt_d = row_cnt_q;
    k_d       = k_q;
    end_d     = end_q;
    prod_d    = prod_q;
    done_d    = 1'b0;
    res_d     = res_o;
    pop_o     = 1'b0;
    col_we    = 1'b0;
    col_waddr = k_q[AW-1:0];
    col_wdata = cmd_q.col;
    ev_we     = 1'b0;
    ev_waddr  = fill_q[AW-1:0];
    ev_wdata  = '0;
    rs_we     = 1'b0;
    rs_waddr  = row_cnt_q;
    rs_wdata  = fill_q + 1'b1;

    case (state_q)
      S_IDLE: begin
        if (head_valid_i) begin
          pop_o        = 1'b1;
          cmd_d        = head_i;
          done_d       = 1'b1;
          res_d.status = ST_OK;
          res_d.position = '0;
          case (head_i.op)
            OP_CLEAR: begin
              fill_d    = '0;
              first_d   = '0;
              row_cnt_d = '0;
            end
            OP_ROW: begin
              if (32'(row_cnt_q) >= 32'(MAX_ROWS)) begin
                res_d.status = ST_RANGE;
              end else if (32'(fill_q) >= 32'(MAX_ENTRIES)) begin
                res_d.status = ST_FULL;
              end else begin
                col_we         = 1'b1;
                col_waddr      = fill_q[AW-1:0];
                col_wdata      = head_i.col;
                ev_we          = 1'b1;
                rs_we          = 1'b1;
                rs_waddr       = row_cnt_q + 1'b1;
                fill_d         = fill_q + 1'b1;
                first_d        = fill_q;
                row_cnt_d      = row_cnt_q + 1'b1;
                res_d.position = POS_W'(fill_q);
              end
            end
            OP_ADJ: begin
              if (row_cnt_q == '0) begin
                res_d.status = ST_RANGE;
              end else if (32'(fill_q) >= 32'(MAX_ENTRIES)) begin
                res_d.status = ST_FULL;
              end else begin
                done_d  = 1'b0;
                k_d     = fill_q;
                state_d = S_ADJ_RD;
              end
            end
            default: begin
              if (head_i.skip) begin
                res_d.status = ST_OK;
              end else if (32'(head_i.row) >= 32'(row_cnt_q) ||
                           32'(head_i.col) >= 32'(row_cnt_q)) begin
                res_d.status = ST_RANGE;
              end else begin
                done_d  = 1'b0;
                state_d = S_ADD_RS0;
              end
            end
          endcase
        end
      end
      S_ADJ_RD, S_ADJ_CMP: begin
        if (state_q == S_ADJ_CMP && col_rdata > cmd_q.col) begin
          col_we    = 1'b1;
          col_wdata = col_rdata;
          k_d       = k_m1;
          state_d   = S_ADJ_RD;
        end else if (state_q == S_ADJ_RD && k_q != first_q) begin
          state_d = S_ADJ_CMP;
        end else begin
          col_we         = 1'b1;
          ev_we          = 1'b1;
          rs_we          = 1'b1;
          fill_d         = fill_q + 1'b1;
          done_d         = 1'b1;
          res_d.status   = ST_OK;
          res_d.position = POS_W'(k_q);
          state_d        = S_IDLE;
        end
      end
      S_ADD_RS0: begin
        k_d     = (cmd_q.row == '0) ? '0 : rs_rdata;
        state_d = S_ADD_RS1;
      end
      S_ADD_RS1: begin
        end_d   = rs_rdata;
        state_d = S_ADD_SCAN;
      end
      S_ADD_SCAN: begin
        if (k_q == end_q) begin
          done_d         = 1'b1;
          res_d.status   = ST_MISSING;
          res_d.position = '0;
          state_d        = S_IDLE;
        end else begin
          state_d = S_ADD_CMP;
        end
      end
      S_ADD_CMP: begin
        if (col_rdata == cmd_q.col) begin
          state_d = S_ADD_MUL;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_ADD_SCAN;
        end
      end
      S_ADD_MUL: begin
        prod_d  = cmd_q.factor * cmd_q.value;
        state_d = S_ADD_ACC;
      end
      S_ADD_ACC: begin
        ev_we          = 1'b1;
        ev_waddr       = k_q[AW-1:0];
        ev_wdata       = sat;
        done_d         = 1'b1;
        res_d.status   = ST_OK;
        res_d.position = POS_W'(k_q);
        state_d        = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    k_q    <= k_d;
    end_q  <= end_d;
    prod_q <= prod_d;
    res_o  <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      fill_q    <= '0;
      first_q   <= '0;
      row_cnt_q <= '0;
      done_o    <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      first_q   <= first_d;
      row_cnt_q <= row_cnt_d;
      done_o    <= done_d;
    end
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= 32'(MAX_ENTRIES)) else $error("fill beyond store");
  a_rows_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(row_cnt_q) <= 32'(MAX_ROWS)) else $error("row count beyond limit");
  a_open_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    first_q <= fill_q) else $error("open row starts past fill");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == S_IDLE && head_valid_i)) else $error("bad pop");
`endif

endmodule

@@ sv/csr_sparse_matrix_assembly.sv @@
// ----------------------------------------------------------------------------
// CSR sparse matrix assembly
// Builds a compressed-sparse-row matrix row by row and accumulates scaled
// Q16.16 values into it.
// ----------------------------------------------------------------------------
// Every transaction produces exactly one result, shown for one cycle with
// done_o, in order; the receiver cannot stall. A two-entry command queue
// takes transactions while busy is low. CLEAR, ROW_START and rejected
// operations complete from the idle state. ADJ shifts larger columns of the
// open row up one slot at a time, and ADD reads the row bounds and scans the
// row one column at a time; both use the single read port of the column
// store. No clearing pass is needed: slots are zeroed as they are allocated.
module csr_sparse_matrix_assembly #(
  parameter int unsigned MAX_ROWS    = csa_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_ENTRIES = csa_pkg::MAX_ENTRIES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  csa_pkg::in_item_t  req_i,
  output logic               done_o,
  output csa_pkg::out_item_t res_o
);
  import csa_pkg::*;

  logic head_valid, pop;
  cmd_t head;

  csa_front u_front (
    .clk_i, .rst_ni, .start, .busy, .req_i,
    .head_valid_o(head_valid), .head_o(head), .pop_i(pop)
  );

  csa_back #(.MAX_ROWS(MAX_ROWS), .MAX_ENTRIES(MAX_ENTRIES)) u_back (
    .clk_i, .rst_ni, .head_valid_i(head_valid), .head_i(head),
    .pop_o(pop), .done_o, .res_o
  );

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CSR sparse matrix assembly testbench
// Drives clear, row start, sorted insert and scaled accumulate transactions,
// predicts each result and every stored value, and checks results in order.
// ----------------------------------------------------------------------------
module tb_top;
  import csa_pkg::*;

  localparam int NROWS = 1024;
  localparam int NENT = 8192;
  localparam int WDOG_LIMIT = 200000;

  class csr_scoreboard;
    int unsigned row_ptr[NROWS+1];
    logic [9:0] col_of[NENT];
    logic signed [31:0] val_of[NENT];
    int unsigned nrows;
    int unsigned nfill;
    out_item_t pending[$];
    int errors;

    function void wipe();
      foreach (val_of[i]) val_of[i] = '0;
      foreach (row_ptr[i]) row_ptr[i] = 0;
      nrows = 0;
      nfill = 0;
    endfunction

    function longint scaled(logic signed [31:0] f, logic signed [31:0] v);
      longint p;
      longint q;
      p = longint'(f) * longint'(v) + 64'sd32768;
      q = p >>> 16;
      return q;
    endfunction

    function void note(in_item_t t);
      out_item_t r;
      int unsigned place;
      int unsigned k;
      longint s;
      bit hit;
      r.status = ST_OK;
      r.position = '0;
      case (op_e'(t.op))
        OP_CLEAR: begin
          foreach (val_of[i]) val_of[i] = '0;
          nrows = 0;
          nfill = 0;
          row_ptr[0] = 0;
        end
        OP_ROW: begin
          if (nrows >= NROWS) r.status = ST_RANGE;
          else if (nfill >= NENT) r.status = ST_FULL;
          else begin
            col_of[nfill] = t.col;
            val_of[nfill] = '0;
            r.position = nfill;
            nfill++;
            nrows++;
            row_ptr[nrows] = nfill;
          end
        end
        OP_ADJ: begin
          if (nrows == 0) r.status = ST_RANGE;
          else if (nfill >= NENT) r.status = ST_FULL;
          else begin
            place = nfill;
            for (int unsigned j = row_ptr[nrows-1]; j < nfill; j++) begin
              if (col_of[j] > t.col) begin
                place = j;
                break;
              end
            end
            for (int unsigned j = nfill; j > place; j--) col_of[j] = col_of[j-1];
            col_of[place] = t.col;
            val_of[nfill] = '0;
            nfill++;
            row_ptr[nrows] = nfill;
            r.position = place;
          end
        end
        default: begin
          if (t.factor == 0) begin
          end else if (t.row >= nrows || t.col >= nrows) r.status = ST_RANGE;
          else begin
            hit = 0;
            for (k = row_ptr[t.row]; k < row_ptr[t.row+1]; k++) begin
              if (col_of[k] == t.col) begin
                hit = 1;
                break;
              end
            end
            if (!hit) r.status = ST_MISSING;
            else begin
              s = longint'(val_of[k]) + scaled(t.factor, t.value);
              if (s > 64'sd2147483647) s = 64'sd2147483647;
              if (s < -64'sd2147483648) s = -64'sd2147483648;
              val_of[k] = s;
              r.position = k;
            end
          end
        end
      endcase
      pending.push_back(r);
    endfunction

    function void check(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status=%0d position=%0d", $time, got.status,
                 got.position);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.position !== want.position) begin
        $display("%0t: position expected %0d actual %0d", $time, want.position,
                 got.position);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic start = 0;
  logic busy;
  in_item_t req_i = '0;
  logic done_o;
  out_item_t res_o;
  int idle_pct = 0;
  int wdog = 0;
  csr_scoreboard sb = new();

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  csr_sparse_matrix_assembly uut (
    .clk_i, .rst_ni, .start, .busy, .req_i, .done_o, .res_o
  );

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check(res_o);
    if (rst_ni && ((start && !busy) || done_o)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog > WDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send(logic [1:0] op, logic [9:0] r, logic [9:0] c,
                      logic signed [31:0] v, logic signed [31:0] f);
    in_item_t t;
    t.op = op;
    t.row = r;
    t.col = c;
    t.value = v;
    t.factor = f;
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk_i);
    end
    start <= 1;
    req_i <= t;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note(t);
  endtask

  function automatic logic [31:0] rnd_q();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0001_0000;
      3: return $urandom_range(262143) - 131072;
      default: return $urandom;
    endcase
  endfunction

  task automatic rand_item();
    int unsigned n;
    int k;
    n = sb.nrows;
    k = $urandom_range(99);
    if (k < 2) send(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
    else if (k < 17 || n == 0) send(OP_ROW, $urandom, $urandom_range(n < 64 ? 63 : n),
                                    $urandom, $urandom);
    else if (k < 45) send(OP_ADJ, $urandom, $urandom_range(n + 2), $urandom, $urandom);
    else if (k < 93) send(OP_ADD, $urandom_range(n - 1),
                          sb.col_of[$urandom_range(sb.row_ptr[$urandom_range(n - 1)],
                                    sb.nfill - 1)], rnd_q(), rnd_q());
    else send(OP_ADD, $urandom, $urandom, $urandom, $urandom_range(1) ? 0 : $urandom);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    start <= 0;
    while (sb.pending.size() != 0 && guard < WDOG_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (40) @(posedge clk_i);
  endtask

  initial begin
    int phase_pct[4] = '{0, 55, 0, 20};
    sb.errors = 0;
    sb.wipe();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send(OP_ADJ, 0, 5, 0, 0);
    send(OP_ADD, 0, 0, 32'h10000, 32'h10000);
    send(OP_ADD, 0, 0, 32'h10000, 0);
    send(OP_ROW, 10'h3FF, 1, 0, 0);
    send(OP_ADJ, 0, 10'h3FF, 0, 0);
    send(OP_ADJ, 0, 0, 0, 0);
    send(OP_ADJ, 0, 1, 0, 0);
    send(OP_ROW, 0, 0, 0, 0);
    send(OP_ADD, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send(OP_ADD, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send(OP_ADD, 0, 1, 32'h8000_0000, 32'h7FFF_FFFF);
    send(OP_ADD, 0, 1, 32'h8000_0000, 32'h7FFF_FFFF);
    send(OP_ADD, 0, 1, 32'h0000_8000, 32'h0000_0001);
    send(OP_ADD, 0, 1, 32'hFFFF_8000, 32'h0000_0001);
    send(OP_ADD, 1, 1, 32'h0001_0000, 32'h0001_0000);
    send(OP_ADD, 0, 10'h3FF, 1, 1);
    send(OP_ADD, 10'h3FF, 0, 1, 1);
    send(OP_ROW, 0, 5, 0, 0);
    send(OP_ADD, 2, 0, 1, 1);
    send(OP_CLEAR, 10'h3FF, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(OP_ADD, 0, 0, 1, 1);
    for (int i = 0; i < 1024; i++) send(OP_ROW, 0, 10'h3FF, 0, 0);
    send(OP_ROW, 0, 0, 0, 0);
    send(OP_ADD, 10'h3FF, 10'h3FF, $urandom, 32'h0001_0000);
    send(OP_CLEAR, 0, 0, 0, 0);
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = phase_pct[ph];
      for (int i = 0; i < 150; i++) begin
        if (sb.nfill > 1500) send(OP_CLEAR, 0, 0, 0, 0);
        else rand_item();
      end
    end
    idle_pct = 0;
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
